[src/rci_pkg.sv]
`timescale 1ns / 1ps

package rci_pkg;

   localparam int CfgFrac    = 30;
   localparam int CfgWidth   = 31;
   localparam int SqrtBits   = 32;
   localparam int QuotBits   = 31;
   localparam int DivLat     = QuotBits + 2;
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int CsrAddrW   = 3;

   typedef logic signed [31:0] q32_type;

   localparam q32_type QMax = 32'sh7fffffff;
   localparam q32_type QMin = 32'sh80000000;

   typedef enum logic {
      RegCosSq = 1'b0,
      RegSinSq = 1'b1
   } csr_reg_type;

   typedef struct packed {
      q32_type a;
      q32_type h;
      q32_type c;
   } coef_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic q32_type sat_to32(input logic signed [79:0] x);
      q32_type r;
      begin
         if (x > 80'sh7fffffff) begin
            r = QMax;
         end else if (x < -80'sh80000000) begin
            r = QMin;
         end else begin
            r = x[31:0];
         end
         return r;
      end
   endfunction

endpackage

[src/ray_cone_intersect_unit.sv]
`timescale 1ns / 1ps

// Ray against infinite double cone, Q16.16 by default. One ray is accepted
// every clock cycle while the front is not stalled by a full queue, and its
// result beat passes through 8 front stages forming the quadratic
// coefficients, then the coefficient queue, then 69 back stages. The back
// depth is set by the square root, one root bit per stage over 32 stages, and
// the two dividers, one quotient bit per stage over 31 stages each. The front
// and back stall independently through a four-entry queue, so a held result
// does not stop input until the queue fills. Write the half-angle registers
// only while the block is idle.

module ray_cone_intersect_unit import rci_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // origin_x, origin_y, origin_z, ray_x, ray_y, ray_z, axis_x, axis_y, axis_z
   input  logic [287:0]        req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // distance
   output logic [31:0]         rsp_tdata,
   // hit
   output logic [0:0]          rsp_tuser,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [CfgWidth-1:0] cos_ff, cos_in, sin_ff, sin_in;
   csr_reg_type         csr_sel;
   logic                csr_wr;
   logic                f_valid, pop, hit;
   coef_type            f_coef, head;
   qstat_type           qstat;
   q32_type             hit_dist;

   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cos_in = cos_ff;
      sin_in = sin_ff;
      unique case (csr_sel)
         RegCosSq: begin
            csr_prdata = {1'b0, cos_ff};
            if (csr_wr) cos_in = csr_pwdata[CfgWidth-1:0];
         end
         RegSinSq: begin
            csr_prdata = {1'b0, sin_ff};
            if (csr_wr) sin_in = csr_pwdata[CfgWidth-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= CfgWidth'(973981545);
         sin_ff <= CfgWidth'(99760279);
      end else begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .cos_sq    (cos_ff),
      .sin_sq    (sin_ff),
      .out_valid (f_valid),
      .qstat     (qstat),
      .out_coef  (f_coef)
   );

   rci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_coef),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   rci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (hit),
      .out_dist  (hit_dist)
   );

   assign rsp_tdata = hit_dist;
   assign rsp_tuser = hit;

endmodule

[src/rci_front.sv]
`timescale 1ns / 1ps

module rci_front import rci_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [287:0]        in_data,
   input  logic [CfgWidth-1:0] cos_sq,
   input  logic [CfgWidth-1:0] sin_sq,
   output logic                out_valid,
   input  qstat_type           qstat,
   output coef_type            out_coef
);

   localparam int PW = 64 - FRAC_BITS;
   localparam int CW = 64 - CfgFrac;
   localparam int NS = 8;

   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [CW-1:0] cprod_type;

   typedef struct packed {
      q32_type [2:0]  org;
      q32_type [2:0]  ray;
      q32_type [2:0]  ax;
      prod_type [2:0] pr;
      prod_type [2:0] po;
   } s1_type;

   typedef struct packed {
      q32_type [2:0] org;
      q32_type [2:0] ray;
      q32_type [2:0] ax;
      q32_type       dv;
      q32_type       dp;
   } s2_type;

   typedef struct packed {
      q32_type [2:0]  org;
      q32_type [2:0]  ray;
      prod_type [2:0] mu;
      prod_type [2:0] mw;
      prod_type       pdd;
      prod_type       pdp;
      prod_type       ppp;
   } s3_type;

   typedef struct packed {
      q32_type [2:0] u;
      q32_type [2:0] w;
      q32_type       sdd;
      q32_type       sdp;
      q32_type       spp;
   } s4_type;

   typedef struct packed {
      prod_type [2:0] puu;
      prod_type [2:0] puw;
      prod_type [2:0] pww;
      q32_type        sdd;
      q32_type        sdp;
      q32_type        spp;
   } s5_type;

   typedef struct packed {
      q32_type uu;
      q32_type uw;
      q32_type ww;
      q32_type sdd;
      q32_type sdp;
      q32_type spp;
   } s6_type;

   typedef struct packed {
      cprod_type cuu;
      cprod_type cuw;
      cprod_type cww;
      cprod_type cdd;
      cprod_type cdp;
      cprod_type cpp;
   } s7_type;

   function automatic prod_type mulq(input q32_type x, input q32_type y);
      logic signed [63:0] p;
      begin
         p = x * y;
         return p[63:FRAC_BITS];
      end
   endfunction

   function automatic cprod_type mulc(input logic [CfgWidth-1:0] k, input q32_type x);
      logic signed [63:0] p;
      begin
         p = $signed({1'b0, k}) * x;
         return p[63:CfgFrac];
      end
   endfunction

   logic [NS-1:0] vld_ff, vld_in;
   logic          adv;
   s1_type        s1_ff, s1_in;
   s2_type        s2_ff, s2_in;
   s3_type        s3_ff, s3_in;
   s4_type        s4_ff, s4_in;
   s5_type        s5_ff, s5_in;
   s6_type        s6_ff, s6_in;
   s7_type        s7_ff, s7_in;
   coef_type      s8_ff, s8_in;

   assign adv       = !vld_ff[NS-1] || !qstat.full;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NS-1];
   assign out_coef  = s8_ff;
   assign vld_in    = {vld_ff[NS-2:0], in_valid};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_in.org[i] = in_data[32*i +: 32];
         s1_in.ray[i] = in_data[96 + 32*i +: 32];
         s1_in.ax[i]  = in_data[192 + 32*i +: 32];
         s1_in.pr[i]  = mulq(s1_in.ray[i], s1_in.ax[i]);
         s1_in.po[i]  = mulq(s1_in.org[i], s1_in.ax[i]);
      end

      s2_in.org = s1_ff.org;
      s2_in.ray = s1_ff.ray;
      s2_in.ax  = s1_ff.ax;
      s2_in.dv  = sat_to32(80'(s1_ff.pr[0]) + 80'(s1_ff.pr[1]) + 80'(s1_ff.pr[2]));
      s2_in.dp  = sat_to32(80'(s1_ff.po[0]) + 80'(s1_ff.po[1]) + 80'(s1_ff.po[2]));

      s3_in.org = s2_ff.org;
      s3_in.ray = s2_ff.ray;
      for (int i = 0; i < 3; i++) begin
         s3_in.mu[i] = mulq(s2_ff.ax[i], s2_ff.dv);
         s3_in.mw[i] = mulq(s2_ff.ax[i], s2_ff.dp);
      end
      s3_in.pdd = mulq(s2_ff.dv, s2_ff.dv);
      s3_in.pdp = mulq(s2_ff.dv, s2_ff.dp);
      s3_in.ppp = mulq(s2_ff.dp, s2_ff.dp);

      for (int i = 0; i < 3; i++) begin
         s4_in.u[i] = sat_to32(80'(s3_ff.ray[i]) - 80'(s3_ff.mu[i]));
         s4_in.w[i] = sat_to32(80'(s3_ff.org[i]) - 80'(s3_ff.mw[i]));
      end
      s4_in.sdd = sat_to32(80'(s3_ff.pdd));
      s4_in.sdp = sat_to32(80'(s3_ff.pdp));
      s4_in.spp = sat_to32(80'(s3_ff.ppp));

      for (int i = 0; i < 3; i++) begin
         s5_in.puu[i] = mulq(s4_ff.u[i], s4_ff.u[i]);
         s5_in.puw[i] = mulq(s4_ff.u[i], s4_ff.w[i]);
         s5_in.pww[i] = mulq(s4_ff.w[i], s4_ff.w[i]);
      end
      s5_in.sdd = s4_ff.sdd;
      s5_in.sdp = s4_ff.sdp;
      s5_in.spp = s4_ff.spp;

      s6_in.uu  = sat_to32(80'(s5_ff.puu[0]) + 80'(s5_ff.puu[1]) + 80'(s5_ff.puu[2]));
      s6_in.uw  = sat_to32(80'(s5_ff.puw[0]) + 80'(s5_ff.puw[1]) + 80'(s5_ff.puw[2]));
      s6_in.ww  = sat_to32(80'(s5_ff.pww[0]) + 80'(s5_ff.pww[1]) + 80'(s5_ff.pww[2]));
      s6_in.sdd = s5_ff.sdd;
      s6_in.sdp = s5_ff.sdp;
      s6_in.spp = s5_ff.spp;

      s7_in.cuu = mulc(cos_sq, s6_ff.uu);
      s7_in.cuw = mulc(cos_sq, s6_ff.uw);
      s7_in.cww = mulc(cos_sq, s6_ff.ww);
      s7_in.cdd = mulc(sin_sq, s6_ff.sdd);
      s7_in.cdp = mulc(sin_sq, s6_ff.sdp);
      s7_in.cpp = mulc(sin_sq, s6_ff.spp);

      s8_in.a = sat_to32(80'(s7_ff.cuu) - 80'(s7_ff.cdd));
      s8_in.h = sat_to32(80'(s7_ff.cuw) - 80'(s7_ff.cdp));
      s8_in.c = sat_to32(80'(s7_ff.cww) - 80'(s7_ff.cpp));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

endmodule

[src/rci_queue.sv]
`timescale 1ns / 1ps

module rci_queue import rci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  coef_type  push_data,
   input  logic      pop,
   output coef_type  head,
   output qstat_type qstat
);

   coef_type           mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign qstat.full  = (cnt_ff == (QueueAw + 1)'(QueueDepth));
   assign qstat.empty = (cnt_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueAw + 1)'(do_push) - (QueueAw + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

[src/rci_div.sv]
`timescale 1ns / 1ps

module rci_div import rci_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              adv,
   input  logic signed [34:0] num,
   input  q32_type           den,
   output logic              pos,
   output q32_type           val
);

   localparam int DW = 34 + FRAC_BITS;

   typedef struct packed {
      logic [33:0] mag_n;
      logic [31:0] mag_d;
      logic        same;
   } m_type;

   typedef struct packed {
      logic [DW-1:0]       rem;
      logic [31:0]         d;
      logic [QuotBits-1:0] quot;
      logic                ovf;
      logic                same;
   } d_type;

   m_type m_ff, m_in;
   d_type o_ff, o_in;
   d_type st_ff [QuotBits];
   d_type st_in [QuotBits];

   always_comb begin
      logic [34:0] nn;
      logic [32:0] nd;
      nn = num[34] ? 35'(-num) : 35'(num);
      nd = den[31] ? 33'(-33'(den)) : 33'(den);
      m_in.mag_n = nn[33:0];
      m_in.mag_d = nd[31:0];
      m_in.same  = (num[34] == den[31]);

      o_in.rem  = {m_ff.mag_n, {FRAC_BITS{1'b0}}};
      o_in.d    = m_ff.mag_d;
      o_in.quot = '0;
      o_in.same = m_ff.same;
      o_in.ovf  = 64'({m_ff.mag_n, {FRAC_BITS{1'b0}}}) >= (64'(m_ff.mag_d) << QuotBits);
   end

   for (genvar j = 0; j < QuotBits; j++) begin : g_step
      localparam int K = QuotBits - 1 - j;
      d_type prev;
      logic [63:0] trial;
      if (j == 0) begin : g_first
         assign prev = o_ff;
      end else begin : g_rest
         assign prev = st_ff[j-1];
      end
      assign trial = 64'(prev.d) << K;
      always_comb begin
         st_in[j] = prev;
         if (64'(prev.rem) >= trial) begin
            st_in[j].rem  = prev.rem - trial[DW-1:0];
            st_in[j].quot = prev.quot | (QuotBits'(1) << K);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
         o_ff <= o_in;
         for (int j = 0; j < QuotBits; j++) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign val = st_ff[QuotBits-1].ovf ? QMax : q32_type'({1'b0, st_ff[QuotBits-1].quot});
   assign pos = st_ff[QuotBits-1].same &&
                (st_ff[QuotBits-1].ovf || st_ff[QuotBits-1].quot != '0);

endmodule

[src/rci_back.sv]
`timescale 1ns / 1ps

module rci_back import rci_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  qstat_type qstat,
   input  coef_type  head,
   output logic      pop,
   output logic      out_valid,
   input  logic      out_ready,
   output logic      out_hit,
   output q32_type   out_dist
);

   localparam int NB  = 2 + SqrtBits + 1 + DivLat + 1;

   typedef struct packed {
      logic signed [63:0] hh;
      logic signed [63:0] ac;
      q32_type            h;
      q32_type            a;
   } b1_type;

   typedef struct packed {
      logic [62:0]         rem;
      logic [SqrtBits-1:0] root;
      q32_type             h;
      q32_type             a;
      logic                ok;
   } sq_type;

   typedef struct packed {
      logic signed [34:0] n1;
      logic signed [34:0] n2;
      q32_type            a;
      logic               ok;
   } nm_type;

   logic [NB-1:0]     vld_ff, vld_in;
   logic              adv;
   b1_type            b1_ff, b1_in;
   sq_type            b2_ff, b2_in;
   sq_type            sq_ff [SqrtBits];
   sq_type            sq_in [SqrtBits];
   nm_type            nm_ff, nm_in;
   logic [DivLat-1:0] ok_ff, ok_in;
   logic              hit_ff, hit_in;
   q32_type           dist_ff, dist_in;
   logic              pos1, pos2, p1, p2;
   q32_type           val1, val2;

   assign adv       = !vld_ff[NB-1] || out_ready;
   assign pop       = adv && !qstat.empty;
   assign vld_in    = {vld_ff[NB-2:0], !qstat.empty};
   assign out_valid = vld_ff[NB-1];
   assign out_hit   = hit_ff;
   assign out_dist  = dist_ff;

   always_comb begin
      logic signed [63:0] q;
      b1_in.hh = head.h * head.h;
      b1_in.ac = head.a * head.c;
      b1_in.h  = head.h;
      b1_in.a  = head.a;

      q          = b1_ff.hh - b1_ff.ac;
      b2_in.rem  = q[62:0];
      b2_in.root = '0;
      b2_in.h    = b1_ff.h;
      b2_in.a    = b1_ff.a;
      b2_in.ok   = !q[63] && (b1_ff.a != '0);
   end

   for (genvar j = 0; j < SqrtBits; j++) begin : g_sqrt
      localparam int K = SqrtBits - 1 - j;
      sq_type prev;
      logic [65:0] trial;
      if (j == 0) begin : g_first
         assign prev = b2_ff;
      end else begin : g_rest
         assign prev = sq_ff[j-1];
      end
      assign trial = (66'(prev.root) << (K + 1)) + (66'(1) << (2 * K));
      always_comb begin
         sq_in[j] = prev;
         if (66'(prev.rem) >= trial) begin
            sq_in[j].rem  = prev.rem - trial[62:0];
            sq_in[j].root = prev.root | (SqrtBits'(1) << K);
         end
      end
   end

   always_comb begin
      logic signed [34:0] s;
      s        = $signed({3'b000, sq_ff[SqrtBits-1].root});
      nm_in.n1 = s - 35'(sq_ff[SqrtBits-1].h);
      nm_in.n2 = 35'sd0 - s - 35'(sq_ff[SqrtBits-1].h);
      nm_in.a  = sq_ff[SqrtBits-1].a;
      nm_in.ok = sq_ff[SqrtBits-1].ok;
      ok_in    = {ok_ff[DivLat-2:0], nm_ff.ok};
   end

   rci_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
      .clock (clock),
      .adv   (adv),
      .num   (nm_ff.n1),
      .den   (nm_ff.a),
      .pos   (pos1),
      .val   (val1)
   );

   rci_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
      .clock (clock),
      .adv   (adv),
      .num   (nm_ff.n2),
      .den   (nm_ff.a),
      .pos   (pos2),
      .val   (val2)
   );

   always_comb begin
      p1     = ok_ff[DivLat-1] && pos1;
      p2     = ok_ff[DivLat-1] && pos2;
      hit_in = p1 || p2;
      priority if (p1 && p2) begin
         dist_in = (val2 < val1) ? val2 : val1;
      end else if (p1) begin
         dist_in = val1;
      end else if (p2) begin
         dist_in = val2;
      end else begin
         dist_in = QMax;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         for (int j = 0; j < SqrtBits; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         nm_ff   <= nm_in;
         ok_ff   <= ok_in;
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

endmodule

[src/rci_checker.sv]
`timescale 1ns / 1ps

module rci_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [31:0]         rsp_tdata,
   input logic [0:0]          rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_miss_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'h7fffffff)
      else $error("miss without saturated distance");

   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[31] && rsp_tdata != 32'h0)
      else $error("hit with non-positive distance");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind ray_cone_intersect_unit rci_checker u_rci_checker (.*);

[tb/tb_ray_cone_intersect_unit.sv]
`timescale 1ns / 1ps

module tb_ray_cone_intersect_unit;
   import rci_pkg::*;

   localparam int FracBits   = 16;
   localparam int Latency    = 78;
   localparam int CycleLimit = 400000;
   localparam int LongHold   = 300;

   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
   } cone_hit_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   logic [30:0]  cos_sq;
   logic [30:0]  sin_sq;
   cone_hit_type pending_hits[$];
   int           mismatches;
   int           checked;
   int           hits_seen;
   int           cycles;
   int           hold_cycles;
   bit           sink_free;
   bit           hold_req;
   bit           hold_taken;

   ray_cone_intersect_unit #(.FRAC_BITS(FracBits)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_sh(longint x, int sh);
      return x >>> sh;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint fx_mul(longint x, longint y);
      return floor_sh(x * y, FracBits);
   endfunction

   function automatic longint cfg_mul(longint k, longint x);
      return floor_sh(k * x, CfgFrac);
   endfunction

   function automatic longint dot_sat(longint p[3], longint r[3]);
      return clamp32(fx_mul(p[0], r[0]) + fx_mul(p[1], r[1]) + fx_mul(p[2], r[2]));
   endfunction

   function automatic longint int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic cone_hit_type cone_distance(logic [287:0] data);
      longint org[3], ray[3], ax[3], u[3], w[3];
      longint dv, dp, a, h, c, q, s, t1, t2, best;
      bit found;
      cone_hit_type res;
      for (int i = 0; i < 3; i++) begin
         org[i] = longint'($signed(data[32*i +: 32]));
         ray[i] = longint'($signed(data[32*(3+i) +: 32]));
         ax[i]  = longint'($signed(data[32*(6+i) +: 32]));
      end
      dv = dot_sat(ray, ax);
      dp = dot_sat(org, ax);
      for (int i = 0; i < 3; i++) begin
         u[i] = clamp32(ray[i] - fx_mul(ax[i], dv));
         w[i] = clamp32(org[i] - fx_mul(ax[i], dp));
      end
      a = clamp32(cfg_mul(cos_sq, dot_sat(u, u)) - cfg_mul(sin_sq, clamp32(fx_mul(dv, dv))));
      h = clamp32(cfg_mul(cos_sq, dot_sat(u, w)) - cfg_mul(sin_sq, clamp32(fx_mul(dv, dp))));
      c = clamp32(cfg_mul(cos_sq, dot_sat(w, w)) - cfg_mul(sin_sq, clamp32(fx_mul(dp, dp))));
      best = 64'sd2147483647;
      found = 1'b0;
      q = h * h - a * c;
      if (q >= 0 && a != 0) begin
         s = int_sqrt(longint'(q));
         t1 = clamp32(((-h + s) * (64'sd1 << FracBits)) / a);
         t2 = clamp32(((-h - s) * (64'sd1 << FracBits)) / a);
         if (t1 > 0) begin
            best = t1;
            found = 1'b1;
         end
         if (t2 > 0 && (!found || t2 < best)) begin
            best = t2;
            found = 1'b1;
         end
      end
      res.hit = found;
      res.distance = best[31:0];
      return res;
   endfunction

   task automatic send_ray(logic [287:0] data);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      pending_hits.push_back(cone_distance(data));
      @(negedge clock);
   endtask

   task automatic send_gapped(logic [287:0] data);
      int r;
      r = $urandom_range(0, 99);
      if (r >= 70) req_tvalid <= 1'b0;
      if (r >= 70 && r < 95) repeat ($urandom_range(1, 3)) @(negedge clock);
      else if (r >= 95) repeat ($urandom_range(10, 40)) @(negedge clock);
      send_ray(data);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'(4 * int'(idx));
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == RegCosSq) cos_sq = val[30:0];
      else sin_sq = val[30:0];
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(0, 8 << FracBits)) - (4 << FracBits));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [287:0] random_ray();
      logic [287:0] d;
      int pick;
      pick = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (pick < 2) d[32*i +: 32] = any_word();
         else if (i >= 6) d[32*i +: 32] = 32'($signed($urandom_range(0, 2 << FracBits)) - (1 << FracBits));
         else d[32*i +: 32] = 32'($signed($urandom_range(0, 40 << FracBits)) - (20 << FracBits));
      end
      if (pick >= 2 && pick < 8) begin
         d[32*6 +: 96] = '0;
         d[32*(6 + $urandom_range(0, 2)) +: 32] = ($urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000);
      end
      return d;
   endfunction

   function automatic logic [287:0] pack_ray(int ox, int oy, int oz, int rx, int ry, int rz,
                                             int axx, int ay, int az);
      return {az, ay, axx, rz, ry, rx, oz, oy, ox};
   endfunction

   task automatic test_directed;
      localparam int One = 1 << FracBits;
      send_gapped(pack_ray(0, 0, -5 * One, 0, 0, One, 0, 0, One));
      send_gapped(pack_ray(0, 0, 5 * One, 0, 0, One, 0, 0, One));
      send_gapped(pack_ray(0, 0, 0, One, 0, 0, 0, 0, One));
      send_gapped(pack_ray(One, 0, -5 * One, 0, 0, 0, 0, 0, One));
      send_gapped(pack_ray(10 * One, 0, 0, 0, One, 0, 0, 0, One));
      send_gapped(pack_ray(-3 * One, 0, One, One, 0, 0, 0, 0, One));
      send_gapped(pack_ray(3 * One, 0, One, -One, 0, 0, 0, 0, One));
      send_gapped(pack_ray(0, 0, -One, 0, One / 2, One, 0, 0, One));
      send_gapped(pack_ray(0, 0, -One, 1, 0, 1, 0, 0, One));
      send_gapped({9{32'h7fffffff}});
      send_gapped({9{32'h80000000}});
      send_gapped({9{32'hffffffff}});
      send_gapped('0);
      send_gapped({3{32'h80000000, 32'h7fffffff, 32'h00010000}});
      send_gapped(pack_ray(2 * One, 0, -One, -One, 0, One, 0, 0, One));
      send_gapped(pack_ray(0, One, -One, 0, 0, One, 0, One, 0));
      drain();
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_gapped(random_ray());
   endtask

   task automatic test_angles;
      write_csr(RegCosSq, 32'h0);
      write_csr(RegSinSq, 32'h40000000);
      test_random(40);
      drain();
      write_csr(RegCosSq, 32'h40000000);
      write_csr(RegSinSq, 32'h0);
      test_random(40);
      drain();
      write_csr(RegCosSq, 32'hffffffff);
      write_csr(RegSinSq, 32'h7fffffff);
      test_random(30);
      drain();
      write_csr(RegCosSq, 32'd536870912);
      write_csr(RegSinSq, 32'd536870912);
      test_random(40);
      drain();
      write_csr(RegCosSq, $urandom_range(0, 32'h40000000));
      write_csr(RegSinSq, $urandom_range(0, 32'h40000000));
      test_random(30);
      drain();
   endtask

   task automatic test_backpressure;
      hold_req = 1'b1;
      for (int n = 0; n < 120; n++) send_ray(random_ray());
      drain();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken  <= 1'b1;
         hold_cycles <= LongHold;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (sink_free) begin
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:69]:  rsp_tready <= 1'b1;
            [70:96]: rsp_tready <= 1'b0;
            default: hold_cycles <= $urandom_range(10, 60);
         endcase
      end
   end

   always @(posedge clock) begin
      cone_hit_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected beat: hit %0d distance %h",
                                          rsp_tuser, rsp_tdata);
         end else begin
            want = pending_hits.pop_front();
            checked <= checked + 1;
            if (want.hit) hits_seen <= hits_seen + 1;
            if (want.hit !== rsp_tuser[0] || want.distance !== rsp_tdata) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected hit %0d distance %h, got hit %0d distance %h",
                           want.hit, want.distance, rsp_tuser, rsp_tdata);
            end
         end
      end
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_ray_cone_intersect_unit: done, errors");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      checked = 0;
      hits_seen = 0;
      cycles = 0;
      hold_cycles = 0;
      sink_free = 1'b0;
      hold_req = 1'b0;
      hold_taken = 1'b0;
      cos_sq = 31'd973981545;
      sin_sq = 31'd99760279;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(200);
      drain();
      test_backpressure();
      sink_free = 1'b1;
      test_random(40);
      drain();
      sink_free = 1'b0;
      test_angles();
      drain();
      $display("covered %0d rays, %0d hits, default and extreme half angles,", checked, hits_seen);
      $display("random gaps on both sides and a long result hold-off");
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("tb_ray_cone_intersect_unit: done, clean");
      end else begin
         $display("tb_ray_cone_intersect_unit: done, errors");
      end
      $finish;
   end

endmodule
